/* rtl/core/slew_profile_time_planner_top_macros.svh */
// Assertion macros for the slew planner.
`ifndef SLEW_PROFILE_TIME_PLANNER_TOP_MACROS_SVH
`define SLEW_PROFILE_TIME_PLANNER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SPT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property violated");
`define SPT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition");
`else
`define SPT_ASSERT(label, clk, rst, prop)
`define SPT_NEVER(label, clk, rst, expr)
`endif
`endif

/* rtl/core/spt_pkg.sv */
package spt_pkg;

  localparam int ANGLE_W = 32;
  localparam int LIMIT_W = 31;
  localparam int TIME_W  = 32;
  localparam int DIFF_W  = 33;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    REG_RATE  = 1'b0,
    REG_ACCEL = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [DIFF_W-1:0]  d;
    logic [LIMIT_W-1:0] r;
    logic [LIMIT_W-1:0] a;
    logic               coast;
  } spt_cls_t;

endpackage

/* rtl/core/spt_if.sv */
interface spt_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] target_angle;
  logic [31:0] start_angle;
  modport source (output valid, target_angle, start_angle, input ready);
  modport sink (input valid, target_angle, start_angle, output ready);
endinterface

interface spt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] ramp_end_time;
  logic [31:0] coast_end_time;
  logic [31:0] decel_end_time;
  logic        coast_skipped;
  modport source (output valid, ramp_end_time, coast_end_time, decel_end_time,
                  coast_skipped, input ready);
  modport sink (input valid, ramp_end_time, coast_end_time, decel_end_time,
                coast_skipped, output ready);
endinterface

interface spt_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

/* rtl/core/spt_front.sv */
module spt_front import spt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  spt_req_if.sink     req,
  spt_cfg_if.sink     cfg,
  input  logic        q_ready,
  output logic        q_push,
  output spt_cls_t    q_data
);

  logic [LIMIT_W-1:0] rate_limit;
  logic [LIMIT_W-1:0] accel_limit;

  logic               advance;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]  dabs;
  logic [LIMIT_W-1:0] r_eff;
  logic [LIMIT_W-1:0] a_eff;

  logic               f1_valid;
  logic [DIFF_W-1:0]  f1_d;
  logic [LIMIT_W-1:0] f1_r;
  logic [LIMIT_W-1:0] f1_a;

  logic               f2_valid;
  logic [DIFF_W-1:0]  f2_d;
  logic [LIMIT_W-1:0] f2_r;
  logic [LIMIT_W-1:0] f2_a;
  logic [63:0]        f2_da;
  logic [61:0]        f2_rr;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit  <= 31'd65536;
      accel_limit <= 31'd65536;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_RATE:  rate_limit  <= cfg.wdata[LIMIT_W-1:0];
        REG_ACCEL: accel_limit <= cfg.wdata[LIMIT_W-1:0];
      endcase
    end
  end

  assign advance   = !f2_valid || q_ready;
  assign req.ready = advance;

  assign diff  = $signed({req.target_angle[31], req.target_angle})
               - $signed({req.start_angle[31], req.start_angle});
  assign dabs  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign r_eff = (rate_limit == '0) ? 31'd1 : rate_limit;
  assign a_eff = (accel_limit == '0) ? 31'd1 : accel_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (advance) begin
      f1_valid <= req.valid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1_d  <= dabs;
      f1_r  <= r_eff;
      f1_a  <= a_eff;
      f2_d  <= f1_d;
      f2_r  <= f1_r;
      f2_a  <= f1_a;
      f2_da <= 64'(f1_d) * 64'(f1_a);
      f2_rr <= 62'(f1_r) * 62'(f1_r);
    end
  end

  // coast kept when d*a > 2*r*r
  assign q_push       = f2_valid && q_ready;
  assign q_data.d     = f2_d;
  assign q_data.r     = f2_r;
  assign q_data.a     = f2_a;
  assign q_data.coast = f2_da > {1'b0, f2_rr, 1'b0};

endmodule

/* rtl/core/spt_queue.sv */
`include "slew_profile_time_planner_top_macros.svh"

module spt_queue import spt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  spt_cls_t push_data,
  output logic     ready,
  input  logic     pop,
  output logic     valid,
  output spt_cls_t head
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  spt_cls_t      mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign ready = count != (PW+1)'(DEPTH);
  assign valid = count != '0;
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  `SPT_NEVER(a_count_range, clk, rst, count > (PW+1)'(DEPTH))
  `SPT_ASSERT(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + (PW+1)'(1)))
  `SPT_NEVER(a_pop_empty, clk, rst, pop && (count == '0))

endmodule

/* rtl/core/spt_div.sv */
module spt_div #(
  parameter int NW = 48,
  parameter int DW = 31,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic [SW-1:0] side_out
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW + 1) ? HW : DW + 1;

  logic [CW-1:0] hx;
  logic [CW-1:0] dx;
  logic          ovf0;

  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] low_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic          ovf_q  [QW];
  logic [SW-1:0] side_q [QW];

  logic [DW-1:0] rem_n  [QW];
  logic [QW-1:0] low_n  [QW];
  logic [QW-1:0] quo_n  [QW];
  logic [DW-1:0] den_n  [QW];
  logic          ovf_n  [QW];
  logic [SW-1:0] side_n [QW];

  assign hx   = CW'(num[NW-1:QW]);
  assign dx   = CW'(den);
  assign ovf0 = hx >= dx;

  // one quotient bit per stage
  always_comb begin
    logic [DW-1:0] rem_i;
    logic [QW-1:0] low_i;
    logic [QW-1:0] quo_i;
    logic [DW:0]   t;
    logic [DW:0]   sub;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rem_i     = ovf0 ? '0 : hx[DW-1:0];
        low_i     = num[QW-1:0];
        quo_i     = '0;
        den_n[k]  = den;
        ovf_n[k]  = ovf0;
        side_n[k] = side_in;
      end else begin
        rem_i     = rem_q[k-1];
        low_i     = low_q[k-1];
        quo_i     = quo_q[k-1];
        den_n[k]  = den_q[k-1];
        ovf_n[k]  = ovf_q[k-1];
        side_n[k] = side_q[k-1];
      end
      t        = {rem_i, low_i[QW-1]};
      sub      = t - {1'b0, den_n[k]};
      ge       = t >= {1'b0, den_n[k]};
      rem_n[k] = ge ? sub[DW-1:0] : t[DW-1:0];
      low_n[k] = low_i << 1;
      quo_n[k] = {quo_i[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= rem_n[k];
        low_q[k] <= low_n[k];
        quo_q[k] <= quo_n[k];
        den_q[k] <= den_n[k];
        ovf_q[k] <= ovf_n[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) begin
        side_q[k] <= '0;
      end
    end else if (en) begin
      for (int k = 0; k < QW; k++) begin
        side_q[k] <= side_n[k];
      end
    end
  end

  assign quo      = quo_q[QW-1];
  assign ovf      = ovf_q[QW-1];
  assign side_out = side_q[QW-1];

endmodule

/* rtl/core/spt_sqrt.sv */
module spt_sqrt #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [63:0]   rad,
  input  logic [SW-1:0] side_in,
  output logic [31:0]   root,
  output logic [SW-1:0] side_out
);

  localparam int NS = 32;

  logic [33:0]   rem_q  [NS];
  logic [63:0]   rad_q  [NS];
  logic [31:0]   root_q [NS];
  logic [SW-1:0] side_q [NS];

  logic [33:0]   rem_n  [NS];
  logic [63:0]   rad_n  [NS];
  logic [31:0]   root_n [NS];
  logic [SW-1:0] side_n [NS];

  // one root bit per stage
  always_comb begin
    logic [33:0] rem_i;
    logic [63:0] rad_i;
    logic [31:0] root_i;
    logic [35:0] t;
    logic [35:0] trial;
    logic [35:0] sub;
    logic        ge;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        rem_i     = '0;
        rad_i     = rad;
        root_i    = '0;
        side_n[k] = side_in;
      end else begin
        rem_i     = rem_q[k-1];
        rad_i     = rad_q[k-1];
        root_i    = root_q[k-1];
        side_n[k] = side_q[k-1];
      end
      t         = {rem_i, rad_i[63:62]};
      trial     = {2'b00, root_i, 2'b01};
      sub       = t - trial;
      ge        = t >= trial;
      rem_n[k]  = ge ? sub[33:0] : t[33:0];
      rad_n[k]  = rad_i << 2;
      root_n[k] = {root_i[30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k]  <= rem_n[k];
        rad_q[k]  <= rad_n[k];
        root_q[k] <= root_n[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) begin
        side_q[k] <= '0;
      end
    end else if (en) begin
      for (int k = 0; k < NS; k++) begin
        side_q[k] <= side_n[k];
      end
    end
  end

  assign root     = root_q[NS-1];
  assign side_out = side_q[NS-1];

endmodule

/* rtl/core/spt_back.sv */
module spt_back import spt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  spt_cls_t q_data,
  output logic     q_pop,
  spt_rsp_if.source rsp
);

  localparam int NNW = (2 * FRAC_BITS + 34 > 65) ? 2 * FRAC_BITS + 34 : 65;
  localparam int NTW = 32 + FRAC_BITS;
  localparam int NQW = 33 + FRAC_BITS;
  localparam int NSW = 2 + DIFF_W + 2 * LIMIT_W;

  logic               en;
  logic [NSW-1:0]     n_side;
  logic [63:0]        n_quo;
  logic               n_ovf;
  logic               n_valid;
  logic               n_coast;
  logic [DIFF_W-1:0]  n_d;
  logic [LIMIT_W-1:0] n_r;
  logic [LIMIT_W-1:0] n_a;

  logic [TIME_W-1:0]  t_quo;
  logic               t_ovf;
  logic               t_coast;
  logic [TIME_W-1:0]  c_quo;
  logic               c_ovf;
  logic               c_nsat;
  logic [31:0]        s_root;
  logic               s_valid;

  logic [TIME_W-1:0]  ramp_c;
  logic [TIME_W-1:0]  coast_c;
  logic [TIME_W:0]    sum_c;
  logic [TIME_W-1:0]  ramp_o;
  logic [TIME_W-1:0]  coast_o;
  logic [TIME_W-1:0]  decel_o;

  assign en    = !rsp.valid || rsp.ready;
  assign q_pop = en && q_valid;

  // 2*d*2^(2F) / a, flagged when the radicand reaches 2^64
  spt_div #(.NW(NNW), .DW(LIMIT_W), .QW(64), .SW(NSW)) u_div_n (
    .clk(clk), .rst(rst), .en(en),
    .num(NNW'({q_data.d, 1'b0}) << (2 * FRAC_BITS)),
    .den(q_data.a),
    .side_in({q_pop, q_data.coast, q_data.d, q_data.r, q_data.a}),
    .quo(n_quo), .ovf(n_ovf), .side_out(n_side)
  );

  assign {n_valid, n_coast, n_d, n_r, n_a} = n_side;

  spt_div #(.NW(NTW), .DW(LIMIT_W), .QW(TIME_W), .SW(1)) u_div_t (
    .clk(clk), .rst(rst), .en(en),
    .num(NTW'({n_r, 1'b0}) << FRAC_BITS),
    .den(n_a),
    .side_in(n_coast),
    .quo(t_quo), .ovf(t_ovf), .side_out(t_coast)
  );

  spt_div #(.NW(NQW), .DW(LIMIT_W), .QW(TIME_W), .SW(1)) u_div_q (
    .clk(clk), .rst(rst), .en(en),
    .num(NQW'(n_d) << FRAC_BITS),
    .den(n_r),
    .side_in(n_ovf),
    .quo(c_quo), .ovf(c_ovf), .side_out(c_nsat)
  );

  spt_sqrt #(.SW(1)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .rad(n_quo),
    .side_in(n_valid),
    .root(s_root), .side_out(s_valid)
  );

  assign ramp_c  = t_ovf ? '1 : t_quo;
  assign coast_c = c_ovf ? '1 : c_quo;
  assign sum_c   = {1'b0, ramp_c} + {1'b0, coast_c};

  always_comb begin
    if (t_coast) begin
      ramp_o  = ramp_c;
      coast_o = coast_c;
      decel_o = sum_c[TIME_W] ? '1 : sum_c[TIME_W-1:0];
    end else if (c_nsat) begin
      ramp_o  = '1;
      coast_o = '1;
      decel_o = '1;
    end else begin
      ramp_o  = s_root;
      coast_o = s_root;
      decel_o = s_root[31] ? '1 : {s_root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.ramp_end_time  <= ramp_o;
      rsp.coast_end_time <= coast_o;
      rsp.decel_end_time <= decel_o;
      rsp.coast_skipped  <= !t_coast;
    end
  end

endmodule

/* rtl/core/slew_profile_time_planner_top.sv */
// Slew profile time planner.
// req: one word per maneuver, target_angle and start_angle (signed Q16.16).
// rsp: one word per request, in order: ramp, coast and decel end times
//   (Q16.16 s, saturating at all ones) and coast_skipped.
// cfg: writes rate_limit (index 0) and accel_limit (index 1); always ready.
//   Write only while no request is in flight.
// Throughput: one word per cycle while rsp is not held, with or without coast.
// Path: front stages f1 and f2 (abs diff, d*a and r*r compare), the queue,
//   the pipelined divider for the radicand, the parallel ramp/coast
//   dividers and square root, then the output register.
// Reset: limits return to 1.0; all pipeline stages and the queue empty.
// Stall: a held rsp freezes the back pipeline; the 4-word queue then fills
//   and req.ready drops once the front stages back up. No word is lost.
module slew_profile_time_planner_top import spt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  spt_req_if.sink   req,
  spt_cfg_if.sink   cfg,
  spt_rsp_if.source rsp
);

  logic     q_ready;
  logic     q_push;
  spt_cls_t q_in;
  logic     q_valid;
  logic     q_pop;
  spt_cls_t q_head;

  spt_front u_front (
    .clk(clk), .rst(rst), .req(req), .cfg(cfg),
    .q_ready(q_ready), .q_push(q_push), .q_data(q_in)
  );

  spt_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_in), .ready(q_ready),
    .pop(q_pop), .valid(q_valid), .head(q_head)
  );

  spt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_data(q_head), .q_pop(q_pop),
    .rsp(rsp)
  );

endmodule

/* dv/slew_profile_time_planner_top_tb.sv */
module slew_profile_time_planner_top_tb;
  import spt_pkg::*;

  typedef struct packed {
    logic [31:0] ramp;
    logic [31:0] coast_end;
    logic [31:0] decel;
    logic        skipped;
  } slew_times_t;

  logic clk;
  logic rst;
  int   errors;
  bit   done;
  int   send_idle_pct;
  int   recv_stall_pct;

  logic [30:0] rate_q;
  logic [30:0] accel_q;
  slew_times_t times_q[$];

  spt_req_if req();
  spt_rsp_if rsp();
  spt_cfg_if cfg();

  slew_profile_time_planner_top i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .cfg(cfg),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("slew_profile_time_planner_top_tb: FAIL");
    $finish;
  end

  function automatic logic [63:0] sqrt_floor(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] sat(logic [63:0] v);
    return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
  endfunction

  function automatic slew_times_t plan_times(logic [31:0] tgt, logic [31:0] st);
    logic [63:0] r, a, d, t, q, m, q1, r1, n, s;
    logic signed [63:0] diff;
    slew_times_t o;
    r = (rate_q == 0) ? 64'd1 : {33'd0, rate_q};
    a = (accel_q == 0) ? 64'd1 : {33'd0, accel_q};
    diff = $signed({{32{tgt[31]}}, tgt}) - $signed({{32{st[31]}}, st});
    d = (diff < 0) ? -diff : diff;
    if (d * a > 2 * r * r) begin
      t = ((2 * r) << 16) / a;
      q = (d << 16) / r;
      o.ramp = sat(t);
      o.coast_end = sat(q);
      o.decel = sat(t + q);
      o.skipped = 1'b0;
    end else begin
      m = (2 * d) << 16;
      q1 = m / a;
      r1 = m % a;
      o.skipped = 1'b1;
      if ((q1 >> 48) != 0) begin
        o.ramp = '1;
        o.coast_end = '1;
        o.decel = '1;
      end else begin
        n = (q1 << 16) + ((r1 << 16) / a);
        s = sqrt_floor(n);
        o.ramp = sat(s);
        o.coast_end = o.ramp;
        o.decel = sat(2 * s);
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // valid stays high after a word so back-to-back words get one drive per edge
  task automatic send_word(logic [31:0] tgt, logic [31:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.target_angle <= tgt;
    req.start_angle <= st;
    do @(posedge clk); while (!req.ready);
    times_q.push_back(plan_times(tgt, st));
  endtask

  task automatic drain();
    int n;
    n = 0;
    req.valid <= 1'b0;
    while (times_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (130) @(posedge clk);
  endtask

  task automatic write_limit(cfg_reg_t idx, logic [31:0] v);
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_RATE) rate_q = v[30:0];
    else accel_q = v[30:0];
  endtask

  always @(posedge clk) begin
    slew_times_t w;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (times_q.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          w = times_q.pop_front();
          if (rsp.ramp_end_time !== w.ramp)
            report_mismatch("ramp", rsp.ramp_end_time, w.ramp);
          if (rsp.coast_end_time !== w.coast_end)
            report_mismatch("coast_end", rsp.coast_end_time, w.coast_end);
          if (rsp.decel_end_time !== w.decel)
            report_mismatch("decel", rsp.decel_end_time, w.decel);
          if (rsp.coast_skipped !== w.skipped)
            report_mismatch("skipped", rsp.coast_skipped, w.skipped);
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(200000) - 100000;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return ($urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000) ^ $urandom_range(255);
    endcase
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(3))
      0: return {1'b0, 31'($urandom)};
      1: return $urandom_range(1, 65536 * 8);
      2: return $urandom_range(1, 255);
      default: return 32'h7FFFFFFF - $urandom_range(255);
    endcase
  endfunction

  task automatic test_directed();
    send_word(32'h0, 32'h0);
    send_word(32'h7FFFFFFF, 32'h80000000);
    send_word(32'h80000000, 32'h7FFFFFFF);
    send_word(32'h00010000, 32'h0);
    send_word(32'h0, 32'h00040000);
    send_word(32'h00020000, 32'h0);
    send_word(32'h00020001, 32'h0);
    send_word(32'hFFFFFFFF, 32'h00000001);
    send_word(32'h00000001, 32'h00000000);
  endtask

  task automatic test_limit_extremes();
    write_limit(REG_RATE, 32'h7FFFFFFF);
    write_limit(REG_ACCEL, 32'h1);
    test_directed();
    write_limit(REG_RATE, 32'h1);
    write_limit(REG_ACCEL, 32'h7FFFFFFF);
    test_directed();
    write_limit(REG_RATE, 32'h0);
    write_limit(REG_ACCEL, 32'hFFFFFFFF);
    test_directed();
    write_limit(REG_RATE, 32'h1);
    write_limit(REG_ACCEL, 32'h1);
    test_directed();
  endtask

  task automatic test_random(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    write_limit(REG_RATE, rand_limit());
    write_limit(REG_ACCEL, rand_limit());
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      send_word(rand_angle(), rand_angle());
    end
  endtask

  initial begin
    int wait_n;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rate_q = 31'd65536;
    accel_q = 31'd65536;
    rst = 1'b1;
    req.valid = 1'b0;
    req.target_angle = '0;
    req.start_angle = '0;
    cfg.valid = 1'b0;
    cfg.index = 1'b0;
    cfg.wdata = '0;
    rsp.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limit_extremes();
    for (int p = 0; p < 5; p++) begin
      test_random(0, 0, 50);
      test_random(70, 0, 50);
      test_random(0, 70, 50);
      test_random(16, 16, 50);
    end
    req.valid <= 1'b0;
    wait_n = 0;
    while (times_q.size() != 0 && wait_n < 400000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (150) @(posedge clk);
    if (errors == 0 && times_q.size() == 0) begin
      $display("slew_profile_time_planner_top_tb: PASS");
    end else begin
      $display("slew_profile_time_planner_top_tb: FAIL");
    end
    $finish;
  end
endmodule
